[sv/pfu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfu_pkg
// Shared types, codes and helpers for the pixel format unpack block.
// ----------------------------------------------------------------------------
package pfu_pkg;

	localparam int FMT_REGS = 4;

	localparam logic [2:0] CFG_PACKED = 3'd0;
	localparam logic [2:0] CFG_COUNT  = 3'd1;
	localparam logic [2:0] CFG_PART0  = 3'd2;
	localparam logic [2:0] CFG_PART1  = 3'd3;
	localparam logic [2:0] CFG_PART2  = 3'd4;
	localparam logic [2:0] CFG_PART3  = 3'd5;

	localparam logic [1:0] PACK_NONE = 2'd0;
	localparam logic [1:0] PACK_8    = 2'd1;
	localparam logic [1:0] PACK_16   = 2'd2;
	localparam logic [1:0] PACK_32   = 2'd3;

	localparam logic [3:0] MODE_UNORM   = 4'd0;
	localparam logic [3:0] MODE_SNORM   = 4'd1;
	localparam logic [3:0] MODE_USCALED = 4'd2;
	localparam logic [3:0] MODE_SSCALED = 4'd3;
	localparam logic [3:0] MODE_UINT    = 4'd4;
	localparam logic [3:0] MODE_SINT    = 4'd5;
	localparam logic [3:0] MODE_UFLOAT  = 4'd6;
	localparam logic [3:0] MODE_SFLOAT  = 4'd7;
	localparam logic [3:0] MODE_SRGB    = 4'd8;

	localparam logic [2:0] COMP_R = 3'd0;
	localparam logic [2:0] COMP_G = 3'd1;
	localparam logic [2:0] COMP_B = 3'd2;
	localparam logic [2:0] COMP_A = 3'd3;

	localparam logic [2:0]  COUNT_RST  = 3'd4;
	localparam logic [13:0] FMT_RST0   = 14'd8;
	localparam logic [13:0] FMT_RST1   = 14'd2056;
	localparam logic [13:0] FMT_RST2   = 14'd4104;
	localparam logic [13:0] FMT_RST3   = 14'd6152;

	localparam logic [63:0] ONE_BITS     = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] NEG_ONE_BITS = 64'hBFF0_0000_0000_0000;

	typedef enum logic [1:0] {
		KIND_RAW,
		KIND_NUM,
		KIND_REP
	} kind_t;

	typedef struct packed {
		logic [63:0] value;
		logic [6:0]  width;
		logic [3:0]  mode;
		logic        pk;
	} lane_in_t;

	typedef struct packed {
		logic [63:0] bits;
		logic        err;
	} lane_out_t;

	typedef struct packed {
		logic [63:0] red;
		logic [63:0] green;
		logic [63:0] blue;
		logic [63:0] alpha;
		logic        err;
	} pixel_t;

	function automatic logic [6:0] fmt_width(input logic [13:0] f);
		return f[6:0];
	endfunction

	function automatic logic [3:0] fmt_mode(input logic [13:0] f);
		return f[10:7];
	endfunction

	function automatic logic [2:0] fmt_comp(input logic [13:0] f);
		return f[13:11];
	endfunction

	function automatic logic [63:0] mask64(input logic [6:0] w);
		logic [63:0] m;
		if (w >= 7'd64) begin
			m = '1;
		end else begin
			m = (64'd1 << w[5:0]) - 64'd1;
		end
		return m;
	endfunction

endpackage

[sv/pfu_extract.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfu_extract
// Splits the raw pixel into one field per part, packed or byte aligned.
// ----------------------------------------------------------------------------
module pfu_extract #(
	parameter int MAX_PARTS = 4
) (
	input  logic                clk,
	input  logic                en,
	input  logic [1:0]          pack_code,
	input  logic [2:0]          part_num,
	input  logic [13:0]         fmt [pfu_pkg::FMT_REGS],
	input  logic [63:0]         raw_word0,
	input  logic [63:0]         raw_word1,
	input  logic [63:0]         raw_word2,
	input  logic [63:0]         raw_word3,
	output pfu_pkg::lane_in_t   lanes_s1 [MAX_PARTS]
);
	import pfu_pkg::*;

	lane_in_t lanes_d [MAX_PARTS];

	always_comb begin
		logic [255:0] raw_all;
		logic [31:0]  word32;
		logic [8:0]   shamt;
		logic [5:0]   off;
		logic [6:0]   w;
		logic [63:0]  pf;
		logic [255:0] sh;
		logic         pk;
		raw_all = {raw_word3, raw_word2, raw_word1, raw_word0};
		pk = (pack_code != PACK_NONE);
		case (pack_code)
			PACK_8:  word32 = {24'b0, raw_word0[7:0]};
			PACK_16: word32 = {16'b0, raw_word0[15:0]};
			PACK_32: word32 = raw_word0[31:0];
			default: word32 = '0;
		endcase
		for (int i = 0; i < MAX_PARTS; i++) begin
			w = fmt_width(fmt[i]);
			shamt = '0;
			off = '0;
			for (int j = 0; j < MAX_PARTS; j++) begin
				if (j > i && 3'(j) < part_num) begin
					shamt = shamt + 9'(fmt_width(fmt[j]));
				end
				if (j < i) begin
					off = off + 6'(fmt[j][6:3]);
				end
			end
			if (shamt >= 9'd32) begin
				pf = '0;
			end else begin
				pf = ({32'b0, word32} >> shamt[4:0]) & mask64(w);
			end
			sh = raw_all >> {off, 3'b0};
			lanes_d[i].value = pk ? pf : (sh[63:0] & mask64(w));
			lanes_d[i].width = w;
			lanes_d[i].mode  = fmt_mode(fmt[i]);
			lanes_d[i].pk    = pk;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_s1 <= lanes_d;
		end
	end

endmodule

[sv/pfu_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfu_lane
// Converts one part to an IEEE double; six registered stages.
// ----------------------------------------------------------------------------
module pfu_lane (
	input  logic               clk,
	input  logic               en,
	input  pfu_pkg::lane_in_t  lane_in,
	output pfu_pkg::lane_out_t lane_out
);
	import pfu_pkg::*;

	typedef struct packed {
		kind_t              kind;
		logic               err;
		logic               sign;
		logic [63:0]        rawb;
		logic signed [11:0] base;
		logic [95:0]        x;
		logic [5:0]         k;
	} work_t;

	typedef enum logic [1:0] {
		SF_UF10,
		SF_UF11,
		SF_HALF,
		SF_SINGLE
	} sf_t;

	work_t dec, s2, dbl_a, s3, dbl_b, s4, s5;
	logic [3:0]  nz_s5;
	logic [3:0]  lzl_s5 [4];
	logic [3:0]  nz_d;
	logic [3:0]  lzl_d [4];
	work_t s6;
	logic [95:0] xs_s6;
	logic [11:0] e_s6;
	logic [95:0] xs_d;
	logic [11:0] e_d;
	lane_out_t   res_d;

	// decode
	always_comb begin
		logic [6:0]  w;
		logic [63:0] v;
		logic [63:0] maskw;
		logic [63:0] mag_s;
		logic        neg;
		logic        std_w;
		logic        okp;
		logic        do_num, do_rep, do_flt;
		sf_t         fsel;
		logic [63:0] nmag;
		logic [31:0] rmag;
		logic [5:0]  rk;
		logic [32:0] mk;
		logic signed [11:0] nbase;
		logic        fs;
		logic [7:0]  fe;
		logic        femax;
		logic [22:0] fm;
		logic [22:0] fml;
		logic signed [11:0] fbias;
		logic signed [11:0] fmb;
		w = lane_in.width;
		v = lane_in.value;
		maskw = mask64(w);
		mag_s = (~v + 64'd1) & maskw;
		neg = v[6'(w - 7'd1)];
		std_w = (w == 7'd8) || (w == 7'd16) || (w == 7'd32) || (w == 7'd64);
		okp = lane_in.pk && (w >= 7'd1) && (w <= 7'd31);
		do_num = 1'b0;
		do_rep = 1'b0;
		do_flt = 1'b0;
		fsel = SF_HALF;
		nmag = '0;
		rmag = '0;
		rk = '0;
		nbase = '0;
		dec = '0;
		dec.kind = KIND_RAW;
		case (lane_in.mode)
			MODE_UNORM, MODE_SRGB: begin
				if (lane_in.pk ? okp : std_w) begin
					if (w == 7'd64) begin
						do_num = 1'b1;
						nmag = v;
						nbase = 12'sd0;
					end else begin
						do_rep = 1'b1;
						rmag = v[31:0];
						rk = 6'(w);
					end
				end else begin
					dec.err = 1'b1;
				end
			end
			MODE_SNORM: begin
				if (lane_in.pk ? (okp && w >= 7'd2) : std_w) begin
					dec.sign = neg;
					if (w == 7'd64) begin
						do_num = 1'b1;
						nmag = neg ? mag_s : v;
						nbase = 12'sd1;
					end else begin
						do_rep = 1'b1;
						rmag = neg ? mag_s[31:0] : v[31:0];
						rk = 6'(w - 7'd1);
					end
				end else begin
					dec.err = 1'b1;
				end
			end
			MODE_USCALED, MODE_UINT: begin
				if (lane_in.pk ? okp : std_w) begin
					do_num = 1'b1;
					nmag = v;
					nbase = 12'sd64;
				end else begin
					dec.err = 1'b1;
				end
			end
			MODE_SSCALED, MODE_SINT: begin
				if (lane_in.pk ? okp : std_w) begin
					do_num = 1'b1;
					dec.sign = neg;
					nmag = neg ? mag_s : v;
					nbase = 12'sd64;
				end else begin
					dec.err = 1'b1;
				end
			end
			MODE_UFLOAT: begin
				if (lane_in.pk && w == 7'd10) begin
					do_flt = 1'b1;
					fsel = SF_UF10;
				end else if (lane_in.pk && w == 7'd11) begin
					do_flt = 1'b1;
					fsel = SF_UF11;
				end else begin
					dec.err = 1'b1;
				end
			end
			MODE_SFLOAT: begin
				if (!lane_in.pk && w == 7'd16) begin
					do_flt = 1'b1;
					fsel = SF_HALF;
				end else if (!lane_in.pk && w == 7'd32) begin
					do_flt = 1'b1;
					fsel = SF_SINGLE;
				end else if (!lane_in.pk && w == 7'd64) begin
					dec.rawb = v;
				end else begin
					dec.err = 1'b1;
				end
			end
			default: begin
				dec.err = 1'b1;
			end
		endcase

		case (fsel)
			SF_UF10: begin
				fs = 1'b0;
				fe = {3'b0, v[9:5]};
				femax = (v[9:5] == 5'h1F);
				fm = {18'b0, v[4:0]};
				fml = {v[4:0], 18'b0};
				fbias = 12'sd15;
				fmb = 12'sd5;
			end
			SF_UF11: begin
				fs = 1'b0;
				fe = {3'b0, v[10:6]};
				femax = (v[10:6] == 5'h1F);
				fm = {17'b0, v[5:0]};
				fml = {v[5:0], 17'b0};
				fbias = 12'sd15;
				fmb = 12'sd6;
			end
			SF_HALF: begin
				fs = v[15];
				fe = {3'b0, v[14:10]};
				femax = (v[14:10] == 5'h1F);
				fm = {13'b0, v[9:0]};
				fml = {v[9:0], 13'b0};
				fbias = 12'sd15;
				fmb = 12'sd10;
			end
			default: begin
				fs = v[31];
				fe = v[30:23];
				femax = (v[30:23] == 8'hFF);
				fm = v[22:0];
				fml = v[22:0];
				fbias = 12'sd127;
				fmb = 12'sd23;
			end
		endcase

		if (do_flt) begin
			dec.sign = fs;
			if (femax) begin
				dec.rawb = {fs, 11'h7FF, fml, 29'b0};
				if (fm != '0) begin
					dec.rawb[51] = 1'b1;
				end
			end else if (fe == '0) begin
				do_num = 1'b1;
				nmag = {41'b0, fm};
				nbase = 12'sd1 - fbias - fmb + 12'sd64;
			end else begin
				do_num = 1'b1;
				nmag = {41'b0, fm} | (64'd1 << fmb[4:0]);
				nbase = $signed({4'b0, fe}) - fbias - fmb + 12'sd64;
			end
		end

		if (do_num) begin
			if (nmag == '0) begin
				dec.rawb = {dec.sign, 63'b0};
			end else begin
				dec.kind = KIND_NUM;
				dec.x = {nmag, 32'b0};
				dec.base = nbase;
			end
		end

		mk = (33'd1 << rk) - 33'd1;
		if (do_rep) begin
			if (rmag == '0) begin
				dec.rawb = '0;
			end else if ({1'b0, rmag} == mk) begin
				dec.rawb = {dec.sign, ONE_BITS[62:0]};
			end else if ({1'b0, rmag} > mk) begin
				dec.rawb = NEG_ONE_BITS;
			end else begin
				dec.kind = KIND_REP;
				dec.x = {rmag, 64'b0} << (6'd32 - rk);
				dec.k = rk;
				dec.base = 12'sd0;
			end
		end
	end

	// repeating block expansion, three doublings per stage
	always_comb begin
		dbl_a = s2;
		if (s2.kind == KIND_REP) begin
			for (int j = 0; j < 3; j++) begin
				dbl_a.x = dbl_a.x | (dbl_a.x >> (11'(s2.k) << j));
			end
		end
		dbl_b = s3;
		if (s3.kind == KIND_REP) begin
			for (int j = 3; j < 6; j++) begin
				dbl_b.x = dbl_b.x | (dbl_b.x >> (11'(s3.k) << j));
			end
		end
	end

	// leading zero count by 16-bit groups
	always_comb begin
		logic [15:0] grp;
		for (int g = 0; g < 4; g++) begin
			grp = s4.x[95 - 16 * g -: 16];
			nz_d[g] = |grp;
			lzl_d[g] = 4'd0;
			for (int b = 0; b < 16; b++) begin
				if (grp[b]) begin
					lzl_d[g] = 4'(15 - b);
				end
			end
		end
	end

	// normalize
	always_comb begin
		logic [5:0] lz;
		lz = '0;
		for (int g = 3; g >= 0; g--) begin
			if (nz_s5[g]) begin
				lz = {2'(g), lzl_s5[g]};
			end
		end
		xs_d = s5.x << lz;
		e_d = 12'(12'sd1022 + s5.base - $signed({6'b0, lz}));
	end

	// round and pack
	always_comb begin
		logic [62:0] mag;
		logic        up;
		logic        sticky;
		sticky = (s6.kind == KIND_REP) || (|xs_s6[41:0]);
		up = xs_s6[42] & (sticky | xs_s6[43]);
		mag = {e_s6[10:0], xs_s6[94:43]} + 63'(up);
		res_d.err = s6.err;
		if (s6.kind == KIND_RAW) begin
			res_d.bits = s6.rawb;
		end else begin
			res_d.bits = {s6.sign, mag};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s2 <= dec;
			s3 <= dbl_a;
			s4 <= dbl_b;
			s5 <= s4;
			nz_s5 <= nz_d;
			lzl_s5 <= lzl_d;
			s6 <= s5;
			xs_s6 <= xs_d;
			e_s6 <= e_d;
			lane_out <= res_d;
		end
	end

endmodule

[sv/pfu_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfu_merge
// Routes lane results to R, G, B, A and collects the error flag.
// ----------------------------------------------------------------------------
module pfu_merge #(
	parameter int MAX_PARTS = 4
) (
	input  logic                part_num_unused_guard,
	input  logic [2:0]          part_num,
	input  logic [13:0]         fmt [pfu_pkg::FMT_REGS],
	input  pfu_pkg::lane_out_t  lanes [MAX_PARTS],
	output pfu_pkg::pixel_t     pix
);
	import pfu_pkg::*;

	always_comb begin
		pix.red   = '0;
		pix.green = '0;
		pix.blue  = '0;
		pix.alpha = ONE_BITS;
		pix.err   = 1'b0;
		for (int i = 0; i < MAX_PARTS; i++) begin
			if (part_num_unused_guard && 3'(i) < part_num) begin
				pix.err = pix.err | lanes[i].err;
				case (fmt_comp(fmt[i]))
					COMP_R:  pix.red   = lanes[i].bits;
					COMP_G:  pix.green = lanes[i].bits;
					COMP_B:  pix.blue  = lanes[i].bits;
					COMP_A:  pix.alpha = lanes[i].bits;
					default: ;
				endcase
			end
		end
	end

endmodule

[sv/pixel_format_unpack_to_float.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_unpack_to_float
// Decodes one raw pixel into RGBA doubles under a configured format.
//
//   channel  signals                              direction
//   cfg      cfg_valid/cfg_ready, index, data     in
//   in       in_valid/in_ready, raw_word0..3      in
//   out      out_valid/out_ready, *_bits, error   out
//
// One pixel per cycle sustained unless the output stalls; an input transfer
// passes extract, six lane stages and merge into the output register.
// The whole pipeline advances when the output register is empty or taken;
// an output stall holds every stage. Reset clears valids and loads the
// default format (four 8-bit UNORM parts, R, G, B, A, not packed).
// ----------------------------------------------------------------------------
module pixel_format_unpack_to_float #(
	parameter int MAX_PARTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] raw_word0,
	input  logic [63:0] raw_word1,
	input  logic [63:0] raw_word2,
	input  logic [63:0] raw_word3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] red_bits,
	output logic [63:0] green_bits,
	output logic [63:0] blue_bits,
	output logic [63:0] alpha_bits,
	output logic        format_error
);
	import pfu_pkg::*;

	logic [1:0]  pack_code_q;
	logic [2:0]  part_count_q;
	logic [13:0] fmt_q [FMT_REGS];
	logic [2:0]  part_num;
	logic        en;
	logic [6:0]  vld_q;
	logic        out_valid_q;
	pixel_t      pix;
	pixel_t      pix_q;
	lane_in_t    lanes_s1 [MAX_PARTS];
	lane_out_t   lane_res [MAX_PARTS];

	assign cfg_ready = 1'b1;
	assign en = !out_valid_q || out_ready;
	assign in_ready = en;
	assign part_num = (part_count_q > 3'(MAX_PARTS)) ? 3'(MAX_PARTS) : part_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_code_q  <= PACK_NONE;
			part_count_q <= COUNT_RST;
			fmt_q[0]     <= FMT_RST0;
			fmt_q[1]     <= FMT_RST1;
			fmt_q[2]     <= FMT_RST2;
			fmt_q[3]     <= FMT_RST3;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PACKED: pack_code_q  <= cfg_data[1:0];
				CFG_COUNT:  part_count_q <= cfg_data[2:0];
				CFG_PART0:  fmt_q[0]     <= cfg_data;
				CFG_PART1:  fmt_q[1]     <= cfg_data;
				CFG_PART2:  fmt_q[2]     <= cfg_data;
				CFG_PART3:  fmt_q[3]     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[5:0], in_valid};
			out_valid_q <= vld_q[6];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_q <= pix;
		end
	end

	pfu_extract #(
		.MAX_PARTS(MAX_PARTS)
	) u_extract (
		.clk       (clk),
		.en        (en),
		.pack_code (pack_code_q),
		.part_num  (part_num),
		.fmt       (fmt_q),
		.raw_word0 (raw_word0),
		.raw_word1 (raw_word1),
		.raw_word2 (raw_word2),
		.raw_word3 (raw_word3),
		.lanes_s1  (lanes_s1)
	);

	for (genvar i = 0; i < MAX_PARTS; i++) begin : g_lane
		pfu_lane u_lane (
			.clk      (clk),
			.en       (en),
			.lane_in  (lanes_s1[i]),
			.lane_out (lane_res[i])
		);
	end

	pfu_merge #(
		.MAX_PARTS(MAX_PARTS)
	) u_merge (
		.part_num_unused_guard (1'b1),
		.part_num              (part_num),
		.fmt                   (fmt_q),
		.lanes                 (lane_res),
		.pix                   (pix)
	);

	assign out_valid    = out_valid_q;
	assign red_bits     = pix_q.red;
	assign green_bits   = pix_q.green;
	assign blue_bits    = pix_q.blue;
	assign alpha_bits   = pix_q.alpha;
	assign format_error = pix_q.err;

endmodule

[verif/pixel_format_unpack_to_float_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_unpack_to_float_tb
// Self-checking bench for the pixel unpack block. A local decoder predicts
// the RGBA doubles and error flag for every pixel transfer; results are
// checked in order under random source gaps and sink stalls, across directed
// formats and many random register settings.
// ----------------------------------------------------------------------------
module pixel_format_unpack_to_float_tb;
	import pfu_pkg::*;

	localparam int LIMIT_CYCLES = 600000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [13:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] raw_word0, raw_word1, raw_word2, raw_word3;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] red_bits, green_bits, blue_bits, alpha_bits;
	logic        format_error;

	logic [1:0]  pack_code;
	logic [2:0]  num_parts;
	logic [13:0] part_fmt [4];

	pixel_t      pending_pixels [$];
	int          fail_count;
	int          cycle_count;
	bit          src_steady;
	bit          sink_steady;

	pixel_format_unpack_to_float uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_word0(raw_word0), .raw_word1(raw_word1),
		.raw_word2(raw_word2), .raw_word3(raw_word3),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_bits(red_bits), .green_bits(green_bits),
		.blue_bits(blue_bits), .alpha_bits(alpha_bits),
		.format_error(format_error)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---- decoder ----
	function automatic logic [63:0] u64_to_dbl(input logic [63:0] u);
		int p;
		int sh;
		logic [63:0] keep, rest, half;
		if (u == 64'd0) return 64'd0;
		p = 63;
		while (!u[p]) p--;
		if (p <= 52) return {1'b0, 11'(p + 1023), 52'(u << (52 - p))};
		sh = p - 52;
		keep = u >> sh;
		rest = u & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rest > half || (rest == half && keep[0])) keep = keep + 64'd1;
		if (keep[53]) begin
			keep = keep >> 1;
			p++;
		end
		return {1'b0, 11'(p + 1023), keep[51:0]};
	endfunction

	function automatic logic [63:0] signed_dbl(input logic [63:0] u, input int w);
		logic [63:0] mag;
		if (!u[w-1]) return u64_to_dbl(u);
		mag = (w < 64) ? ((64'd1 << w) - u) : (~u + 64'd1);
		return u64_to_dbl(mag) | (64'd1 << 63);
	endfunction

	function automatic logic [63:0] div_dbl(input logic [63:0] a, input logic [63:0] b,
			input bit clamp);
		real r;
		r = $bitstoreal(a) / $bitstoreal(b);
		if (clamp && r < -1.0) r = -1.0;
		return $realtobits(r);
	endfunction

	function automatic logic [63:0] minifloat_dbl(input logic [63:0] v, input int eb,
			input int mb, input bit has_sign);
		logic [63:0] sgn, emax, e, m, o;
		int bias;
		int p;
		sgn = has_sign ? ((v >> (eb + mb)) & 64'd1) : 64'd0;
		emax = (64'd1 << eb) - 64'd1;
		e = (v >> mb) & emax;
		m = v & ((64'd1 << mb) - 64'd1);
		bias = (1 << (eb - 1)) - 1;
		o = sgn << 63;
		if (e == emax) begin
			o |= 64'h7FF << 52;
			if (m != 0) o |= (m << (52 - mb)) | (64'd1 << 51);
			return o;
		end
		if (e == 0) begin
			if (m == 0) return o;
			p = mb - 1;
			while (p > 0 && !m[p]) p--;
			o |= 64'(p + 1 - bias - mb + 1023) << 52;
			o |= (m - (64'd1 << p)) << (52 - p);
			return o;
		end
		o |= 64'(int'(e) - bias + 1023) << 52;
		o |= m << (52 - mb);
		return o;
	endfunction

	function automatic logic [63:0] decode_packed(input logic [63:0] x, input int w,
			input logic [3:0] mode, inout bit err);
		if (w < 1 || w > 31) begin
			err = 1'b1;
			return 64'd0;
		end
		case (mode)
			MODE_UNORM, MODE_SRGB:
				return div_dbl(u64_to_dbl(x), u64_to_dbl((64'd1 << w) - 1), 1'b0);
			MODE_SNORM: if (w >= 2)
				return div_dbl(signed_dbl(x, w), u64_to_dbl((64'd1 << (w - 1)) - 1), 1'b1);
			MODE_USCALED, MODE_UINT: return u64_to_dbl(x);
			MODE_SSCALED, MODE_SINT: return signed_dbl(x, w);
			MODE_UFLOAT: begin
				if (w == 10) return minifloat_dbl(x, 5, 5, 1'b0);
				if (w == 11) return minifloat_dbl(x, 5, 6, 1'b0);
			end
			default: ;
		endcase
		err = 1'b1;
		return 64'd0;
	endfunction

	function automatic logic [63:0] decode_bytes(input logic [63:0] u, input int w,
			input logic [3:0] mode, inout bit err);
		bit std_w;
		std_w = (w == 8 || w == 16 || w == 32 || w == 64);
		case (mode)
			MODE_UNORM, MODE_SRGB: if (std_w) begin
				if (w == 64) return div_dbl(u64_to_dbl(u), 64'h43F0_0000_0000_0000, 1'b0);
				return div_dbl(u64_to_dbl(u), u64_to_dbl((64'd1 << w) - 1), 1'b0);
			end
			MODE_SNORM: if (std_w) begin
				if (w == 64) return div_dbl(signed_dbl(u, 64), 64'h43E0_0000_0000_0000, 1'b1);
				return div_dbl(signed_dbl(u, w), u64_to_dbl((64'd1 << (w - 1)) - 1), 1'b1);
			end
			MODE_USCALED, MODE_UINT: if (std_w) return u64_to_dbl(u);
			MODE_SSCALED, MODE_SINT: if (std_w) return signed_dbl(u, w);
			MODE_SFLOAT: begin
				if (w == 16) return minifloat_dbl(u, 5, 10, 1'b1);
				if (w == 32) return minifloat_dbl(u, 8, 23, 1'b1);
				if (w == 64) return u;
			end
			default: ;
		endcase
		err = 1'b1;
		return 64'd0;
	endfunction

	function automatic pixel_t decode_pixel(input logic [63:0] wd [4]);
		logic [63:0] parts [4];
		logic [63:0] chan [4];
		logic [63:0] word, fld;
		bit err;
		int n, w, pw, off, nb, b;
		logic [2:0] comp;
		pixel_t px;
		err = 1'b0;
		chan = '{64'd0, 64'd0, 64'd0, ONE_BITS};
		parts = '{64'd0, 64'd0, 64'd0, 64'd0};
		n = (num_parts > 4) ? 4 : num_parts;
		if (pack_code != PACK_NONE) begin
			pw = 8 << (pack_code - 1);
			word = wd[0] & ((64'd1 << pw) - 64'd1);
			for (int i = n - 1; i >= 0; i--) begin
				w = part_fmt[i][6:0];
				fld = (w >= 64) ? word : (word & ((64'd1 << w) - 64'd1));
				parts[i] = decode_packed(fld, w, part_fmt[i][10:7], err);
				word = (w >= 64) ? 64'd0 : (word >> w);
			end
		end else begin
			off = 0;
			for (int i = 0; i < n; i++) begin
				w = part_fmt[i][6:0];
				nb = (w == 8 || w == 16 || w == 32 || w == 64) ? w / 8 : 0;
				fld = 64'd0;
				for (int k = nb - 1; k >= 0; k--) begin
					b = off + k;
					fld = (fld << 8) | ((b < 32) ? 64'(wd[b >> 3][(b & 7) * 8 +: 8]) : 64'd0);
				end
				parts[i] = decode_bytes(fld, w, part_fmt[i][10:7], err);
				off += w / 8;
			end
		end
		for (int i = 0; i < n; i++) begin
			comp = part_fmt[i][13:11];
			if (comp < 4) chan[comp] = parts[i];
		end
		px.red = chan[0];
		px.green = chan[1];
		px.blue = chan[2];
		px.alpha = chan[3];
		px.err = err;
		return px;
	endfunction

	// ---- channel drivers ----
	task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PACKED: pack_code = val[1:0];
			CFG_COUNT:  num_parts = val[2:0];
			default:    part_fmt[idx - CFG_PART0] = val;
		endcase
	endtask

	task automatic drain_pixels();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_format(input logic [1:0] pk, input logic [2:0] cnt,
			input logic [13:0] f0, input logic [13:0] f1,
			input logic [13:0] f2, input logic [13:0] f3);
		drain_pixels();
		write_reg(CFG_PACKED, pk);
		write_reg(CFG_COUNT, cnt);
		write_reg(CFG_PART0, f0);
		write_reg(CFG_PART1, f1);
		write_reg(CFG_PART2, f2);
		write_reg(CFG_PART3, f3);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(input logic [63:0] w0, input logic [63:0] w1,
			input logic [63:0] w2, input logic [63:0] w3);
		int gap;
		logic [63:0] wd [4];
		gap = src_steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_word0 <= w0;
		raw_word1 <= w1;
		raw_word2 <= w2;
		raw_word3 <= w3;
		do @(posedge clk); while (!in_ready);
		wd = '{w0, w1, w2, w3};
		pending_pixels.push_back(decode_pixel(wd));
	endtask

	function automatic logic [13:0] fmt(input int w, input logic [3:0] mode,
			input logic [2:0] comp);
		return {comp, mode, 7'(w)};
	endfunction

	function automatic logic [63:0] rand_word();
		logic [63:0] v;
		case ($urandom_range(0, 5))
			0: v = '1;
			1: v = '0;
			2: for (int k = 0; k < 8; k++)
				case ($urandom_range(0, 4))
					0: v[k*8 +: 8] = 8'h00;
					1: v[k*8 +: 8] = 8'hFF;
					2: v[k*8 +: 8] = 8'h80;
					3: v[k*8 +: 8] = 8'h7F;
					default: v[k*8 +: 8] = 8'($urandom);
				endcase
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic logic [13:0] rand_fmt(input bit packed_fmt);
		logic [3:0] mode;
		int w;
		logic [2:0] comp;
		mode = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		comp = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
		if (packed_fmt) begin
			w = (mode == MODE_UFLOAT) ? $urandom_range(10, 11) : $urandom_range(1, 12);
			if ($urandom_range(0, 3) == 0) w = $urandom_range(1, 31);
		end else begin
			case ($urandom_range(0, 3))
				0: w = 8;
				1: w = 16;
				2: w = 32;
				default: w = 64;
			endcase
			if (mode == MODE_UFLOAT) mode = MODE_SFLOAT;
		end
		if ($urandom_range(0, 12) == 0) w = $urandom_range(0, 127);
		return fmt(w, mode, comp);
	endfunction

	// ---- tests ----
	task automatic test_reset_format();
		send_pixel('0, '0, '0, '0);
		send_pixel('1, '1, '1, '1);
		send_pixel(64'h0000_0000_807F_FF00, rand_word(), rand_word(), rand_word());
	endtask

	task automatic test_unpacked_modes();
		set_format(PACK_NONE, 3'd4, fmt(8, MODE_SNORM, COMP_R), fmt(16, MODE_SFLOAT, COMP_G),
			fmt(32, MODE_SFLOAT, COMP_B), fmt(64, MODE_SFLOAT, COMP_A));
		// snorm min and max codes, half zero/denormal/nan, float and double denormals
		send_pixel(64'h7F80_0001_7C00_0080, 64'hFFF0_0000_0000_0001, '0, '0);
		send_pixel(64'hFFC0_1234_FE01_0001, 64'h7FF8_0000_0000_0000, '0, '0);
		send_pixel(64'h0000_0001_03FF_017F, 64'h0000_0000_0000_0001, '0, '0);
		set_format(PACK_NONE, 3'd4, fmt(64, MODE_UNORM, COMP_R), fmt(64, MODE_SNORM, COMP_G),
			fmt(64, MODE_UINT, COMP_B), fmt(64, MODE_SINT, COMP_A));
		send_pixel('1, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FC01, 64'h8000_0000_0000_0001);
		send_pixel(64'h0000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0020_0000_0000_0003, '1);
		// odd width, ufloat unpacked, unsupported mode; part count and component out of range
		set_format(PACK_NONE, 3'd7, fmt(12, MODE_UNORM, COMP_R), fmt(16, MODE_UFLOAT, COMP_G),
			fmt(8, 4'd15, 3'd3), fmt(64, MODE_SRGB, 3'd7));
		send_pixel(rand_word(), rand_word(), rand_word(), rand_word());
	endtask

	task automatic test_packed_modes();
		set_format(PACK_32, 3'd3, fmt(10, MODE_UFLOAT, COMP_B), fmt(11, MODE_UFLOAT, COMP_G),
			fmt(11, MODE_UFLOAT, COMP_R), fmt(8, MODE_UNORM, COMP_A));
		send_pixel(64'h0000_0000_FFFF_FFFF, '0, '0, '0);
		send_pixel(64'hFFFF_FFFF_F7DF_03C1, '0, '0, '0);
		send_pixel(64'h0000_0000_0000_0401, '0, '0, '0);
		set_format(PACK_16, 3'd4, fmt(5, MODE_SNORM, COMP_R), fmt(1, MODE_SNORM, COMP_G),
			fmt(6, MODE_SINT, COMP_B), fmt(31, MODE_UNORM, COMP_B));
		send_pixel('1, '0, '0, '0);
		send_pixel(64'h0000_0000_0000_8421, '0, '0, '0);
		set_format(PACK_8, 3'd0, '1, '1, '1, '1);
		send_pixel('1, '1, '1, '1);
		set_format(PACK_8, 3'd2, fmt(127, MODE_UINT, COMP_R), fmt(0, MODE_UINT, COMP_G),
			'0, '0);
		send_pixel('1, '0, '0, '0);
		set_format(PACK_32, 3'd4, fmt(31, MODE_SSCALED, COMP_A), fmt(1, MODE_USCALED, COMP_R),
			fmt(2, MODE_SRGB, COMP_G), fmt(3, MODE_UNORM, COMP_A));
		send_pixel(64'h1234_5678_8000_0001, '0, '0, '0);
		send_pixel('1, '0, '0, '0);
	endtask

	task automatic test_random_formats();
		bit pk;
		int phases;
		phases = 28;
		for (int ph = 0; ph < phases; ph++) begin
			pk = $urandom_range(0, 1);
			src_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			set_format(pk ? 2'($urandom_range(1, 3)) : PACK_NONE,
				($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4)),
				rand_fmt(pk), rand_fmt(pk), rand_fmt(pk), rand_fmt(pk));
			repeat (60) send_pixel(rand_word(), rand_word(), rand_word(), rand_word());
		end
		src_steady = 1'b0;
		sink_steady = 1'b0;
	endtask

	// ---- result checking ----
	always @(posedge clk) begin
		pixel_t exp_px;
		logic [63:0] got [5];
		logic [63:0] want [5];
		string names [5];
		cycle_count <= cycle_count + 1;
		if (out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result transfer", $time);
				fail_count++;
			end else begin
				exp_px = pending_pixels.pop_front();
				names = '{"red", "green", "blue", "alpha", "error"};
				got = '{red_bits, green_bits, blue_bits, alpha_bits, 64'(format_error)};
				want = '{exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha, 64'(exp_px.err)};
				for (int k = 0; k < 5; k++)
					if (got[k] !== want[k]) begin
						$display("%0t: %s expected %h got %h", $time, names[k], want[k], got[k]);
						fail_count++;
					end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count > LIMIT_CYCLES) begin
			$display("pixel_format_unpack_to_float_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_steady ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		fail_count = 0;
		cycle_count = 0;
		src_steady = 1'b0;
		sink_steady = 1'b0;
		pack_code = PACK_NONE;
		num_parts = COUNT_RST;
		part_fmt = '{FMT_RST0, FMT_RST1, FMT_RST2, FMT_RST3};
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_PACKED;
		cfg_data <= '0;
		in_valid <= 1'b0;
		raw_word0 <= '0;
		raw_word1 <= '0;
		raw_word2 <= '0;
		raw_word3 <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_format();
		test_unpacked_modes();
		test_packed_modes();
		test_random_formats();
		drain_pixels();
		if (fail_count == 0) begin
			$display("pixel_format_unpack_to_float_tb OK");
		end else begin
			$display("pixel_format_unpack_to_float_tb NOT OK");
		end
		$finish;
	end

endmodule
